@@ hdl/bmd_pkg.sv @@
package bmd_pkg;

  // Default map limits.
  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  // Field widths of the channels.
  localparam int MODE_W     = 2;
  localparam int COORD_W    = 7;
  localparam int SIZE_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_X     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_Y     = 8'd3;

  // Register reset values.
  localparam logic [SIZE_W-1:0] MAP_WIDTH_RST  = 8'd128;
  localparam logic [SIZE_W-1:0] MAP_HEIGHT_RST = 8'd128;

  // Effective map geometry after clamping, shared by the datapath units.
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              wrap_x;
    logic              wrap_y;
  } size_cfg_t;

endpackage

@@ hdl/bmd_in_if.sv @@
interface bmd_in_if;
  logic                         valid;
  logic                         ready;
  logic [bmd_pkg::MODE_W-1:0]   mode;
  logic [bmd_pkg::COORD_W-1:0]  col;
  logic [bmd_pkg::COORD_W-1:0]  row;
  logic                         value;

  modport source (output valid, mode, col, row, value, input ready);
  modport sink (input valid, mode, col, row, value, output ready);
endinterface

@@ hdl/bmd_out_if.sv @@
interface bmd_out_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic is_read_reply;

  modport source (output valid, cell_value, is_read_reply, input ready);
  modport sink (input valid, cell_value, is_read_reply, output ready);
endinterface

@@ hdl/bmd_cfg_if.sv @@
interface bmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bmd_pkg::CFG_IDX_W-1:0]   idx;
  logic [bmd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

@@ hdl/bmd_ram.sv @@
module bmd_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/bmd_cfg_regs.sv @@
module bmd_cfg_regs #(
  parameter int MAX_WIDTH  = bmd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmd_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  bmd_cfg_if.sink            cfg_chan,
  output bmd_pkg::size_cfg_t size
);

  logic [bmd_pkg::SIZE_W-1:0] map_width_r;
  logic [bmd_pkg::SIZE_W-1:0] map_height_r;
  logic                       wrap_x_r;
  logic                       wrap_y_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= bmd_pkg::MAP_WIDTH_RST;
      map_height_r <= bmd_pkg::MAP_HEIGHT_RST;
      wrap_x_r     <= 1'b0;
      wrap_y_r     <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.idx)
        bmd_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_chan.data;
        bmd_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_chan.data;
        bmd_pkg::REG_WRAP_X:     wrap_x_r     <= cfg_chan.data[0];
        bmd_pkg::REG_WRAP_Y:     wrap_y_r     <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // A size of zero acts as one and anything above the maximum acts as the maximum.
  always_comb begin
    if (map_width_r == '0) begin
      size.width = 8'd1;
    end else if ({24'd0, map_width_r} > 32'(MAX_WIDTH)) begin
      size.width = 8'(MAX_WIDTH);
    end else begin
      size.width = map_width_r;
    end
    if (map_height_r == '0) begin
      size.height = 8'd1;
    end else if ({24'd0, map_height_r} > 32'(MAX_HEIGHT)) begin
      size.height = 8'(MAX_HEIGHT);
    end else begin
      size.height = map_height_r;
    end
    size.wrap_x = wrap_x_r;
    size.wrap_y = wrap_y_r;
  end

endmodule

@@ hdl/bmd_row_unit.sv @@
module bmd_row_unit #(
  parameter int WIDTH = bmd_pkg::MAX_WIDTH_DEF
) (
  input  logic [WIDTH-1:0]   row_in,
  input  bmd_pkg::size_cfg_t size,
  output logic [WIDTH-1:0]   hrow,
  output logic [WIDTH-1:0]   mask
);

  localparam int IW = $clog2(WIDTH);

  logic [IW-1:0]    last_idx;
  logic [WIDTH-1:0] left;
  logic [WIDTH-1:0] right;

  assign last_idx = IW'(size.width - 8'd1);

  for (genvar i = 0; i < WIDTH; i++) begin : g_col
    localparam logic [31:0] IDX = i;
    assign mask[i] = IDX < {24'd0, size.width};
    if (i == 0) begin : g_first
      assign left[i] = size.wrap_x & row_in[last_idx];
    end else begin : g_inner_l
      assign left[i] = row_in[i-1];
    end
    // The last column in use takes column zero as its right neighbour under wrap.
    if (i == WIDTH - 1) begin : g_last
      assign right[i] = size.wrap_x & row_in[0];
    end else begin : g_inner_r
      assign right[i] = mask[i+1] ? row_in[i+1] : (size.wrap_x & row_in[0]);
    end
  end

  assign hrow = left | row_in | right;

endmodule

@@ hdl/binary_map_dilate_3x3_top.sv @@
// Binary map of up to MAX_HEIGHT rows by MAX_WIDTH columns with 3x3 dilation.
// Items arrive on in_chan (valid/ready): mode write sets one cell, mode read
// returns one cell, mode dilate replaces every cell in use by the OR of its
// 3x3 neighbourhood. Every item gives exactly one result on out_chan.
// cfg_chan is always ready and sets map width, map height and the wrap flags;
// the user must write it only while idle; the block does not enforce this.
// Writes, reads and the unused mode read the row from the map memory in the
// accepting cycle and write it back or answer once the output slot is free.
// A dilate first reads the last row for the top wrap, then passes one row a
// cycle through the memory's single read port with the write-back trailing
// one row behind, then does one tail write and gives the result.
// The result sits in an output register; while it waits the next item is
// still accepted, and only the finishing step stalls for a free slot.
// After reset the block sweeps all MAX_HEIGHT rows of the map memory to zero,
// one row a cycle, with in_chan not ready; the registers take their reset
// values at once.
module binary_map_dilate_3x3_top #(
  parameter int MAX_WIDTH  = bmd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmd_pkg::MAX_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bmd_in_if.sink    in_chan,
  bmd_out_if.source out_chan,
  bmd_cfg_if.sink   cfg_chan
);

  localparam int AW = $clog2(MAX_HEIGHT);
  localparam int IW = $clog2(MAX_WIDTH);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CELL  = 3'd2;
  localparam logic [2:0] S_DPRE  = 3'd3;
  localparam logic [2:0] S_DRUN  = 3'd4;
  localparam logic [2:0] S_DTAIL = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  bmd_pkg::size_cfg_t size;

  logic [2:0]                   state_r, state_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]                row_cnt_r, row_cnt_nxt;
  logic [bmd_pkg::MODE_W-1:0]   mode_r;
  logic [IW-1:0]                col_r;
  logic [AW-1:0]                row_r;
  logic                         value_r;
  logic                         inside_r;
  logic [MAX_WIDTH-1:0]         a_r, a_nxt;
  logic [MAX_WIDTH-1:0]         b_r, b_nxt;
  logic [MAX_WIDTH-1:0]         old_r, old_nxt;
  logic [MAX_WIDTH-1:0]         hfirst_r, hfirst_nxt;
  logic                         out_valid_r;
  logic                         cell_value_r, cell_value_nxt;
  logic                         is_read_r, is_read_nxt;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [MAX_WIDTH-1:0]         ram_wdata, ram_rdata;
  logic [MAX_WIDTH-1:0]         hrow, mask;
  logic [MAX_WIDTH-1:0]         below, vert, dil_row, cell_row;
  logic [AW-1:0]                last_row;
  logic                         in_acc, slot_free, out_load;

  bmd_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .size     (size)
  );

  bmd_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bmd_row_unit #(
    .WIDTH (MAX_WIDTH)
  ) u_row (
    .row_in (ram_rdata),
    .size   (size),
    .hrow   (hrow),
    .mask   (mask)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign last_row      = AW'(size.height - 8'd1);

  // Vertical pass: rows above, at and below, each already passed horizontally.
  assign below   = (state_r == S_DRUN) ? hrow : (size.wrap_y ? hfirst_r : '0);
  assign vert    = a_r | b_r | below;
  assign dil_row = (vert & mask) | (old_r & ~mask);

  always_comb begin
    cell_row         = ram_rdata;
    cell_row[col_r]  = value_r;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    row_cnt_nxt    = row_cnt_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    old_nxt        = old_r;
    hfirst_nxt     = hfirst_r;
    ram_we         = 1'b0;
    ram_waddr      = row_r;
    ram_wdata      = cell_row;
    ram_re         = 1'b0;
    ram_raddr      = AW'(in_chan.row);
    out_load       = 1'b0;
    cell_value_nxt = 1'b0;
    is_read_nxt    = 1'b0;
    unique case (state_r)
      S_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MAX_HEIGHT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          ram_re = 1'b1;
          if (in_chan.mode == bmd_pkg::MODE_DILATE) begin
            ram_raddr = last_row;
            state_nxt = S_DPRE;
          end else begin
            state_nxt = S_CELL;
          end
        end
      end
      S_CELL: begin
        if (slot_free) begin
          ram_we         = (mode_r == bmd_pkg::MODE_WRITE) && inside_r;
          out_load       = 1'b1;
          is_read_nxt    = (mode_r == bmd_pkg::MODE_READ);
          cell_value_nxt = is_read_nxt && inside_r && ram_rdata[col_r];
          state_nxt      = S_IDLE;
        end
      end
      S_DPRE: begin
        // Last row arrives: it is the neighbour above row zero under wrap.
        b_nxt       = size.wrap_y ? hrow : '0;
        ram_re      = 1'b1;
        ram_raddr   = '0;
        row_cnt_nxt = '0;
        state_nxt   = S_DRUN;
      end
      S_DRUN: begin
        if (row_cnt_r == '0) begin
          hfirst_nxt = hrow;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = row_cnt_r - 1'b1;
          ram_wdata = dil_row;
        end
        a_nxt   = b_r;
        b_nxt   = hrow;
        old_nxt = ram_rdata;
        if (row_cnt_r == last_row) begin
          state_nxt = S_DTAIL;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = row_cnt_r + 1'b1;
          row_cnt_nxt = row_cnt_r + 1'b1;
        end
      end
      S_DTAIL: begin
        ram_we    = 1'b1;
        ram_waddr = last_row;
        ram_wdata = dil_row;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    old_r    <= old_nxt;
    hfirst_r <= hfirst_nxt;
    if (in_acc) begin
      mode_r   <= in_chan.mode;
      col_r    <= IW'(in_chan.col);
      row_r    <= AW'(in_chan.row);
      value_r  <= in_chan.value;
      inside_r <= ({1'b0, in_chan.col} < size.width) && ({1'b0, in_chan.row} < size.height);
    end
    if (out_load) begin
      cell_value_r <= cell_value_nxt;
      is_read_r    <= is_read_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.cell_value    = cell_value_r;
  assign out_chan.is_read_reply = is_read_r;

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("map written while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  a_dilate_trails: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRUN && row_cnt_r != '0) |->
      (ram_we && ram_waddr == row_cnt_r - 1'b1 && (!ram_re || ram_waddr != ram_raddr)))
    else $error("dilate write-back does not trail the row read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_valid_r) |-> out_chan.ready)
    else $error("pending result overwritten");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_CLR && !out_valid_r))
    else $error("reset did not start the clearing sweep");

endmodule
